// ===== hw/rtl/weighted_field_substring_scorer_macros.svh =====
// Assertion macros for the weighted field substring scorer.
// Included by the top-level scorer RTL file, which checks its own logic; no other dependencies.
`ifndef WEIGHTED_FIELD_SUBSTRING_SCORER_MACROS_SVH
`define WEIGHTED_FIELD_SUBSTRING_SCORER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define WFSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("wfss assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WFSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("wfss assertion failed");

`else

`define WFSS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define WFSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/wfss_pkg.sv =====
// Shared types, constants and byte compare function for the substring scorer.
// Used by every RTL module of the block; depends on nothing.
package wfss_pkg;

	// Longest query that the cell row can hold.
	localparam int unsigned PATTERN_MAX = 32;
	localparam int unsigned LEN_W       = $clog2(PATTERN_MAX + 1);
	localparam int unsigned IDX_W       = $clog2(PATTERN_MAX);
	localparam int unsigned CFG_LEN_W   = 6;
	localparam int unsigned WORD_W      = 64;
	localparam int unsigned WORD_BYTES  = WORD_W / 8;
	localparam int unsigned NUM_WORDS   = 4;
	localparam int unsigned QUERY_BYTES = NUM_WORDS * WORD_BYTES;
	localparam int unsigned FIELD_W     = 2;
	localparam int unsigned FLAG_W      = 4;
	localparam int unsigned SCORE_W     = 3;
	localparam int unsigned CFG_IDX_W   = 3;

	// Byte classes for the case-folding compare.
	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] UPPER_A     = 8'h41;
	localparam logic [7:0] UPPER_Z     = 8'h5A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	// Field weights.
	localparam logic [SCORE_W-1:0] WEIGHT_TITLE   = 3'd3;
	localparam logic [SCORE_W-1:0] WEIGHT_TAGS    = 3'd2;
	localparam logic [SCORE_W-1:0] WEIGHT_SUMMARY = 3'd1;
	localparam logic [SCORE_W-1:0] WEIGHT_BODY    = 3'd1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_WORD_0 = 3'd0,
		REG_PATTERN_WORD_1 = 3'd1,
		REG_PATTERN_WORD_2 = 3'd2,
		REG_PATTERN_WORD_3 = 3'd3,
		REG_PATTERN_LENGTH = 3'd4
	} cfg_reg_t;

	// Per-request control broadcast along the cell row.
	typedef struct packed {
		logic advance;  // a text byte enters the row
		logic clear;    // field or document ends: the window empties
	} cell_ctrl_t;

	typedef logic [PATTERN_MAX-1:0][7:0] query_t;

	// Lower-case letters A to Z; every other byte passes unchanged.
	function automatic logic [7:0] fold_byte(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= UPPER_A && b <= UPPER_Z) begin
			r = b + CASE_OFFSET;
		end
		return r;
	endfunction

	// Bytes below 0x80 compare without case; others must be identical.
	function automatic logic bytes_equal(input logic [7:0] h, input logic [7:0] n);
		logic eq;
		if (h < ASCII_LIMIT && n < ASCII_LIMIT) begin
			eq = (fold_byte(h) == fold_byte(n));
		end else begin
			eq = (h == n);
		end
		return eq;
	endfunction

	// Weighted sum of the per-field match flags.
	function automatic logic [SCORE_W-1:0] score_of(input logic [FLAG_W-1:0] f);
		logic [SCORE_W-1:0] s;
		s = '0;
		if (f[0]) s = s + WEIGHT_TITLE;
		if (f[1]) s = s + WEIGHT_TAGS;
		if (f[2]) s = s + WEIGHT_SUMMARY;
		if (f[3]) s = s + WEIGHT_BODY;
		return s;
	endfunction

endpackage

// ===== hw/rtl/wfss_cell.sv =====
// One cell of the match row: holds one window byte and whether that slot is filled.
// Depends on wfss_pkg.
module wfss_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wfss_pkg::cell_ctrl_t ctrl,
	input  logic [7:0]           byte_in,
	input  logic                 fill_in,
	input  logic [7:0]           query_byte,
	input  logic                 in_use,
	output logic [7:0]           byte_q,
	output logic                 fill_q,
	output logic                 term
);
	import wfss_pkg::*;

	// Compare the byte that this slot takes in with its aligned query byte.
	always_comb begin
		term = ~in_use | (fill_in & bytes_equal(byte_in, query_byte));
	end

	// Take the neighbor's byte on a shift; a field or document end empties the slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
			fill_q <= 1'b0;
		end else if (ctrl.clear) begin
			byte_q <= '0;
			fill_q <= 1'b0;
		end else if (ctrl.advance) begin
			byte_q <= byte_in;
			fill_q <= fill_in;
		end
	end

endmodule

// ===== hw/rtl/wfss_chain.sv =====
// Row of window cells; cell k holds the k-th newest byte of the current field.
// Depends on wfss_pkg and wfss_cell.
module wfss_chain (
	input  logic                     clk,
	input  logic                     arst_n,
	input  wfss_pkg::cell_ctrl_t     ctrl,
	input  logic [7:0]               text_byte,
	input  wfss_pkg::query_t         query,
	input  logic [wfss_pkg::LEN_W-1:0] act_len,
	output logic                     hit
);
	import wfss_pkg::*;

	logic [PATTERN_MAX-1:0][7:0] byte_vec;
	logic [PATTERN_MAX-1:0]      fill_vec;
	logic [PATTERN_MAX-1:0]      term_vec;

	// Each cell takes its neighbor's byte; the first cell takes the new text byte.
	// The last cell's byte leaves the window at the next shift.
	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		logic [7:0]       byte_in;
		logic             fill_in;
		logic             in_use;
		logic [IDX_W-1:0] q_idx;

		if (k == 0) begin : g_head
			assign byte_in = text_byte;
			assign fill_in = 1'b1;
		end else begin : g_body
			assign byte_in = byte_vec[k-1];
			assign fill_in = fill_vec[k-1];
		end

		// Window byte k lines up with query byte (length - 1 - k).
		assign in_use = (LEN_W'(k) < act_len);
		assign q_idx  = IDX_W'(act_len - LEN_W'(k + 1));

		wfss_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.byte_in    (byte_in),
			.fill_in    (fill_in),
			.query_byte (query[q_idx]),
			.in_use     (in_use),
			.byte_q     (byte_vec[k]),
			.fill_q     (fill_vec[k]),
			.term       (term_vec[k])
		);
	end

	// A full match needs every slot in use to be filled and equal; an empty query never hits.
	assign hit = ctrl.advance & (act_len != '0) & (&term_vec);

endmodule

// ===== hw/rtl/weighted_field_substring_scorer.sv =====
// Weighted field substring scorer: one text byte per cycle through a row of window cells,
// unless the request side stalls. The single result per document appears in the output
// register the cycle after the request that carries the document end. The request side
// stalls only while that register holds a result that the output side stalls; otherwise
// one request enters every cycle. The window keeps raw bytes, so a query written between
// requests applies to the bytes already seen in the field.
`include "weighted_field_substring_scorer_macros.svh"

module weighted_field_substring_scorer (
	input  logic                             clk,
	input  logic                             arst_n,
	// Configuration write channel.
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [wfss_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wfss_pkg::WORD_W-1:0]      cfg_data,
	// Text request channel.
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       text_byte,
	input  logic                             byte_valid,
	input  logic [wfss_pkg::FIELD_W-1:0]     field_id,
	input  logic                             field_end,
	input  logic                             document_end,
	// Result channel.
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [wfss_pkg::SCORE_W-1:0]     score,
	output logic [wfss_pkg::FLAG_W-1:0]      match_flags
);
	import wfss_pkg::*;

	logic [NUM_WORDS-1:0][WORD_W-1:0] pattern_word_q;
	logic [CFG_LEN_W-1:0]             pattern_length_q;
	logic [LEN_W-1:0]                 act_len;
	query_t                           query;
	cell_ctrl_t                       ctrl;
	logic                             accept;
	logic                             hit;
	logic [FLAG_W-1:0]                found_q;
	logic [FLAG_W-1:0]                found_next;
	logic                             out_valid_q;
	logic [SCORE_W-1:0]               score_q;
	logic [FLAG_W-1:0]                flags_q;

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_word_q   <= '0;
			pattern_length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_PATTERN_WORD_0: pattern_word_q[0] <= cfg_data;
				REG_PATTERN_WORD_1: pattern_word_q[1] <= cfg_data;
				REG_PATTERN_WORD_2: pattern_word_q[2] <= cfg_data;
				REG_PATTERN_WORD_3: pattern_word_q[3] <= cfg_data;
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[CFG_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Query bytes in cell order; bytes beyond the pattern words read as zero.
	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_query
		if (k < QUERY_BYTES) begin : g_word
			assign query[k] = pattern_word_q[k / WORD_BYTES][(k % WORD_BYTES) * 8 +: 8];
		end else begin : g_zero
			assign query[k] = 8'h00;
		end
	end

	// A length above the row size behaves as the full row.
	always_comb begin
		if (int'(pattern_length_q) > PATTERN_MAX) begin
			act_len = LEN_W'(PATTERN_MAX);
		end else begin
			act_len = LEN_W'(pattern_length_q);
		end
	end

	// Request handshake and the control broadcast to the cells.
	assign in_stall     = out_valid_q & out_stall;
	assign accept       = in_valid & ~in_stall;
	assign ctrl.advance = accept & byte_valid;
	assign ctrl.clear   = accept & (field_end | document_end);

	wfss_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.text_byte (text_byte),
		.query     (query),
		.act_len   (act_len),
		.hit       (hit)
	);

	// A full match is credited to the field of the byte that completes it.
	always_comb begin
		found_next = found_q;
		if (hit) begin
			found_next = found_q | (FLAG_W'(1) << field_id);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= '0;
		end else if (accept) begin
			if (document_end) begin
				found_q <= '0;
			end else begin
				found_q <= found_next;
			end
		end
	end

	// Output register: loads at a document end, empties when the result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && document_end) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && document_end) begin
			score_q <= score_of(found_next);
			flags_q <= found_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign score       = score_q;
	assign match_flags = flags_q;

	// A document end always leaves its result, built from this document's flags.
	`WFSS_ASSERT_NEXT(a_doc_result, clk, arst_n, accept && document_end, out_valid_q && flags_q == $past(found_next))
	// The flag set starts empty for the next document.
	`WFSS_ASSERT_NEXT(a_doc_clears, clk, arst_n, accept && document_end, found_q == '0)
	// An empty query never reports a match.
	`WFSS_ASSERT_IMPL(a_empty_query, clk, arst_n, accept && act_len == '0, !hit)
	// Requests stall only behind a held result.
	`WFSS_ASSERT_IMPL(a_stall_cause, clk, arst_n, in_stall, out_valid_q && out_stall)

endmodule

// ===== verif/weighted_field_substring_scorer_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the weighted field substring scorer: queued text requests,
// a scoring predictor, per-field result checks and random idling on both channels.
// Depends on wfss_pkg and the weighted_field_substring_scorer RTL.
module weighted_field_substring_scorer_tb;
	import wfss_pkg::*;

	// One text request as the driver presents it.
	typedef struct packed {
		logic [7:0]         text;
		logic               has_byte;
		logic [FIELD_W-1:0] fld;
		logic               fend;
		logic               dend;
		logic               after_drain;  // hold this request until no score is pending
	} text_req_t;

	// One document score as the block returns it.
	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [FLAG_W-1:0]  flags;
	} doc_score_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [7:0]           text_byte = '0;
	logic                 byte_valid = 1'b0;
	logic [FIELD_W-1:0]   field_id = '0;
	logic                 field_end = 1'b0;
	logic                 document_end = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [SCORE_W-1:0]   score;
	logic [FLAG_W-1:0]    match_flags;

	weighted_field_substring_scorer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.text_byte(text_byte),
		.byte_valid(byte_valid),
		.field_id(field_id),
		.field_end(field_end),
		.document_end(document_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.score(score),
		.match_flags(match_flags)
	);

	always #10 clk = ~clk;

	text_req_t   pending_reqs[$];
	doc_score_t  expected_scores[$];
	int unsigned fail_count = 0;
	int unsigned queued_items = 0;
	int unsigned queued_docs = 0;
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	bit          hold_req = 1'b0;
	logic        receiver_hold = 1'b0;
	logic [7:0]  phase_query [QUERY_BYTES];

	// Scorer state as the predictor sees it.
	logic [NUM_WORDS-1:0][WORD_W-1:0] query_word = '0;
	logic [CFG_LEN_W-1:0]             query_len = '0;
	logic [7:0]                       window [PATTERN_MAX] = '{default: 8'h00};
	int unsigned                      window_fill = 0;
	logic [FLAG_W-1:0]                fields_hit = '0;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
	endfunction

	// ASCII bytes compare without case; anything with the top bit set must be identical.
	function automatic bit chars_agree(input logic [7:0] a, input logic [7:0] b);
		if (a[7] || b[7])
			return a == b;
		return to_lower(a) == to_lower(b);
	endfunction

	// Advance the predicted scorer by one accepted request and queue any document score.
	function automatic void score_request(input text_req_t r);
		int unsigned i;
		int unsigned n;
		bit          hit;
		doc_score_t  res;
		if (r.has_byte) begin
			for (i = PATTERN_MAX - 1; i > 0; i--)
				window[i] = window[i-1];
			window[0] = r.text;
			if (window_fill < PATTERN_MAX)
				window_fill++;
			n = (query_len > PATTERN_MAX) ? PATTERN_MAX : query_len;
			hit = (n != 0) && (window_fill >= n);
			for (i = 0; i < n; i++) begin
				if (!chars_agree(window[n-1-i], query_word[i>>3][8*(i&7) +: 8]))
					hit = 1'b0;
			end
			if (hit)
				fields_hit[r.fld] = 1'b1;
		end
		if (r.fend || r.dend) begin
			for (i = 0; i < PATTERN_MAX; i++)
				window[i] = 8'h00;
			window_fill = 0;
		end
		if (r.dend) begin
			res.flags = fields_hit;
			res.score = SCORE_W'((fields_hit[0] ? 3 : 0) + (fields_hit[1] ? 2 : 0)
				+ fields_hit[2] + fields_hit[3]);
			expected_scores.push_back(res);
			fields_hit = '0;
		end
	endfunction

	// Flip the case of a letter at random.
	function automatic logic [7:0] vary_case(input logic [7:0] c);
		if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A && $urandom_range(1) == 1)
			return c ^ 8'h20;
		return c;
	endfunction

	// Filler text that often resembles pieces of the query.
	function automatic logic [7:0] noise_byte(input int unsigned qn);
		int unsigned pick;
		pick = $urandom_range(99);
		if (qn != 0 && pick < 40)
			return vary_case(phase_query[$urandom_range(qn - 1)]);
		if (pick < 70)
			return vary_case(8'h61 + 8'($urandom_range(25)));
		return 8'($urandom);
	endfunction

	task automatic queue_req(input logic [7:0] t, input logic v, input logic [FIELD_W-1:0] f,
			input logic fe, input logic de);
		pending_reqs.push_back('{t, v, f, fe, de, 1'b0});
		queued_items++;
	endtask

	// Build one random document; fields carry the query whole, cut short, or not at all.
	task automatic queue_document(input int unsigned qn, input bit after_drain);
		text_req_t          doc[$];
		text_req_t          r;
		logic [7:0]         txt[$];
		int unsigned        nf, f, k, cut, style;
		logic [FIELD_W-1:0] fid;
		nf = ($urandom_range(99) < 85) ? 4 : $urandom_range(5);
		for (f = 0; f < nf; f++) begin
			fid = (nf == 4) ? FIELD_W'(f) : FIELD_W'($urandom_range(3));
			if (nf == 4 && $urandom_range(99) < 20)
				continue;
			txt = {};
			repeat ($urandom_range(3)) txt.push_back(noise_byte(qn));
			style = $urandom_range(99);
			if (style < 45) begin
				for (k = 0; k < qn; k++)
					txt.push_back(vary_case(phase_query[k]));
			end else if (style < 60 && qn > 1) begin
				cut = $urandom_range(qn - 1, 1);
				for (k = 0; k < cut; k++)
					txt.push_back(vary_case(phase_query[k]));
			end
			repeat ($urandom_range(3)) txt.push_back(noise_byte(qn));
			foreach (txt[k]) begin
				r = '{txt[k], 1'b1, fid, 1'b0, 1'b0, 1'b0};
				// A byte tagged with another field while the window keeps running.
				if ($urandom_range(99) < 4)
					r.fld = FIELD_W'($urandom_range(3));
				doc.push_back(r);
			end
			style = $urandom_range(99);
			if (txt.size() == 0 || style < 20)
				doc.push_back('{8'($urandom), 1'b0, fid, 1'b1, 1'b0, 1'b0});
			else if (style < 90)
				doc[doc.size()-1].fend = 1'b1;
			// Otherwise the field runs into the next one without an end mark.
			if ($urandom_range(99) < 8)
				doc.push_back('{8'($urandom), 1'b0, fid, 1'b0, 1'b0, 1'b0});
		end
		if (doc.size() == 0 || $urandom_range(99) < 25)
			doc.push_back('{8'($urandom), 1'b0, FIELD_W'($urandom_range(3)),
				1'($urandom_range(1)), 1'b1, 1'b0});
		else
			doc[doc.size()-1].dend = 1'b1;
		doc[0].after_drain = after_drain;
		foreach (doc[k])
			pending_reqs.push_back(doc[k]);
		queued_items += doc.size();
		queued_docs++;
	endtask

	// One register write; cfg_valid stays high across consecutive writes.
	task automatic write_reg(input cfg_reg_t idx, input logic [WORD_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk);
		while (!cfg_ready);
	endtask

	task automatic load_query(input logic [NUM_WORDS-1:0][WORD_W-1:0] w,
			input logic [CFG_LEN_W-1:0] len);
		write_reg(REG_PATTERN_WORD_0, w[0]);
		write_reg(REG_PATTERN_WORD_1, w[1]);
		write_reg(REG_PATTERN_WORD_2, w[2]);
		write_reg(REG_PATTERN_WORD_3, w[3]);
		write_reg(REG_PATTERN_LENGTH, WORD_W'(len));
		cfg_valid <= 1'b0;
		query_word = w;
		query_len = len;
	endtask

	// Wait until every request is in and every score is out, then let the pipe settle.
	task automatic wait_idle();
		do @(posedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_scores.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Request driver: predicts each accepted request, then offers the next one.
	always @(posedge clk or negedge arst_n) begin : drive_requests
		text_req_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			text_byte <= '0;
			byte_valid <= 1'b0;
			field_id <= '0;
			field_end <= 1'b0;
			document_end <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				score_request('{text_byte, byte_valid, field_id, field_end, document_end, 1'b0});
			if (!in_valid || !in_stall) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct
						&& (!pending_reqs[0].after_drain || expected_scores.size() == 0)) begin
					nxt = pending_reqs.pop_front();
					in_valid <= 1'b1;
					text_byte <= nxt.text;
					byte_valid <= nxt.has_byte;
					field_id <= nxt.fld;
					field_end <= nxt.fend;
					document_end <= nxt.dend;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares each accepted score with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin : check_results
		doc_score_t exp_res;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_scores.size() == 0) begin
					$error("unexpected result: score %0d, match_flags %b", score, match_flags);
					fail_count++;
				end else begin
					exp_res = expected_scores.pop_front();
					if (score !== exp_res.score) begin
						$error("score: expected %0d, got %0d", exp_res.score, score);
						fail_count++;
					end
					if (match_flags !== exp_res.flags) begin
						$error("match_flags: expected %b, got %b", exp_res.flags, match_flags);
						fail_count++;
					end
				end
			end
			out_stall <= receiver_hold || ($urandom_range(99) < stall_pct);
		end
	end

	// Long receiver hold-off so the block fills up and stalls its input.
	initial begin : long_holdoff
		wait (hold_req);
		@(posedge clk);
		receiver_hold <= 1'b1;
		repeat (300) @(posedge clk);
		receiver_hold <= 1'b0;
	end

	initial begin : watchdog
		#4_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : run_phases
		logic [NUM_WORDS-1:0][WORD_W-1:0] words;
		logic [CFG_LEN_W-1:0]             len;
		int unsigned                      phase, start, i, pick;
		logic [7:0]                       b;
		bit                               drained_once;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty query straight out of reset: the document scores zero.
		queue_req(8'h41, 1'b1, 2'd0, 1'b0, 1'b0);
		queue_req(8'h00, 1'b0, 2'd0, 1'b1, 1'b1);
		wait_idle();

		// Query "aB" followed by a non-ASCII byte.
		load_query({{3{64'hFFFF_FFFF_FFFF_FFFF}}, 64'h0000_0000_00E9_4261}, 6'd3);
		// Title matches with case folded.
		queue_req(8'h41, 1'b1, 2'd0, 1'b0, 1'b0);
		queue_req(8'h62, 1'b1, 2'd0, 1'b0, 1'b0);
		queue_req(8'hE9, 1'b1, 2'd0, 1'b1, 1'b0);
		// Tags miss: bytes above 0x7F never fold.
		queue_req(8'h61, 1'b1, 2'd1, 1'b0, 1'b0);
		queue_req(8'h62, 1'b1, 2'd1, 1'b0, 1'b0);
		queue_req(8'hC9, 1'b1, 2'd1, 1'b1, 1'b0);
		// Summary changes to body with no end mark; the body gets the credit.
		queue_req(8'h61, 1'b1, 2'd2, 1'b0, 1'b0);
		queue_req(8'h62, 1'b1, 2'd2, 1'b0, 1'b0);
		queue_req(8'hE9, 1'b1, 2'd3, 1'b1, 1'b0);
		// A field end in the middle clears the window.
		queue_req(8'h61, 1'b1, 2'd3, 1'b0, 1'b0);
		queue_req(8'h62, 1'b1, 2'd3, 1'b1, 1'b0);
		queue_req(8'hE9, 1'b1, 2'd3, 1'b0, 1'b0);
		queue_req(8'hFF, 1'b0, 2'd3, 1'b0, 1'b0);
		queue_req(8'h00, 1'b0, 2'd3, 1'b0, 1'b1);
		// Zero byte as data and a marker-only request inside the match.
		queue_req(8'h00, 1'b1, 2'd1, 1'b0, 1'b0);
		queue_req(8'h61, 1'b1, 2'd1, 1'b0, 1'b0);
		queue_req(8'h78, 1'b0, 2'd1, 1'b0, 1'b0);
		queue_req(8'h42, 1'b1, 2'd1, 1'b0, 1'b0);
		queue_req(8'hE9, 1'b1, 2'd1, 1'b1, 1'b1);
		wait_idle();

		queued_items = 0;
		queued_docs = 0;
		drained_once = 1'b0;
		for (phase = 0; phase < 10; phase++) begin
			// Random query mixing letters, other ASCII and high bytes.
			for (i = 0; i < QUERY_BYTES; i++) begin
				pick = $urandom_range(99);
				if (pick < 50)
					b = vary_case(8'h61 + 8'($urandom_range(25)));
				else if (pick < 70)
					b = 8'($urandom_range(127));
				else
					b = 8'($urandom);
				words[i>>3][8*(i&7) +: 8] = b;
			end
			case (phase)
				0: len = 6'd2;
				1: len = 6'd1;
				2: len = 6'd3;
				3: len = 6'd32;
				4: begin
					len = 6'd0;
					words = '1;
				end
				5: begin
					len = 6'd63;
					words = '1;
				end
				6: begin
					len = 6'd5;
					words = '0;
				end
				7: len = 6'd33;
				8: len = CFG_LEN_W'($urandom_range(4, 1));
				default: len = CFG_LEN_W'($urandom_range(6, 1));
			endcase
			for (i = 0; i < QUERY_BYTES; i++)
				phase_query[i] = words[i>>3][8*(i&7) +: 8];
			load_query(words, len);

			case (phase % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 61;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 61;
				end
				default: begin
					idle_pct = 24;
					stall_pct = 24;
				end
			endcase
			if (phase == 2) begin
				idle_pct = 0;
				stall_pct = 0;
				hold_req = 1'b1;
			end

			start = queued_items;
			while (queued_items - start < 60
					|| (phase == 9 && (queued_items < 600 || queued_docs < 48))) begin
				if (phase == 2 && !drained_once && queued_items - start >= 30) begin
					queue_document((len > PATTERN_MAX) ? PATTERN_MAX : len, 1'b1);
					drained_once = 1'b1;
				end else begin
					queue_document((len > PATTERN_MAX) ? PATTERN_MAX : len, 1'b0);
				end
			end
			wait_idle();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0 && expected_scores.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/wfss_pkg.sv
hw/rtl/wfss_cell.sv
hw/rtl/wfss_chain.sv
hw/rtl/weighted_field_substring_scorer.sv
verif/weighted_field_substring_scorer_tb.sv
